// ===== hw/rtl/llg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llg_pkg
// Shared constants, types and codes for the generation-tagged linked LIFO.
// ----------------------------------------------------------------------------
package llg_pkg;

  // Node table depth and generation width
  localparam int NODE_COUNT = 256;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int GEN_BITS   = 32;

  // Fixed field widths
  localparam int KIND_W  = 3;
  localparam int NODE_W  = 8;
  localparam int SIZE_W  = 8;
  localparam int GFLD_W  = 32;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  // Input tdata: node, expect_gen, expect_size, incr_amount, new_gen
  localparam int IN_NODE_LO  = 0;
  localparam int IN_EGEN_LO  = IN_NODE_LO + NODE_W;
  localparam int IN_ESIZE_LO = IN_EGEN_LO + GFLD_W;
  localparam int IN_INCR_LO  = IN_ESIZE_LO + SIZE_W;
  localparam int IN_NGEN_LO  = IN_INCR_LO + GFLD_W;
  localparam int IN_BITS     = IN_NGEN_LO + GFLD_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Output tdata: done_res, node_out, count_out, gen_out, is_empty, size_now, gen_now
  localparam int OUT_BITS    = 1 + NODE_W + SIZE_W + GFLD_W + 1 + SIZE_W + GFLD_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH            = 3'd0,
    K_POP             = 3'd1,
    K_PUSH_IF_GEN     = 3'd2,
    K_POP_IF_GEN_SIZE = 3'd3,
    K_DETACH_ALL      = 3'd4,
    K_DETACH_OR_ADD   = 3'd5,
    K_DETACH_IF_GEN   = 3'd6,
    K_READ_LINK       = 3'd7
  } llg_kind_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } llg_state_t;

  typedef struct packed {
    logic capture;  // latch the item and start the link read
    logic exec;     // commit the operation and load the result register
  } llg_cmd_t;

endpackage

// ===== hw/rtl/linked_lifo_with_generation_tag.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_lifo_with_generation_tag
// Generation-tagged intrusive LIFO over numbered nodes, one atomic step per
// transfer.
//
//   channel  | ports                     | content
//   ---------+---------------------------+-------------------------------------
//   input    | in_tvalid/tready/tdata/   | tuser: kind; tdata: node, expect_gen,
//            | tuser                     | expect_size, incr_amount, new_gen
//   result   | out_tvalid/tready/tdata   | done_res, node_out, count_out, gen_out,
//            |                           | is_empty, size_now, gen_now
//
// Per item, with no overlap: accept and read the node link memory, then commit
// state and the link write-back. The result sits in an output register; the
// next item is accepted while it waits, and its commit holds until the result
// register is taken. Synchronous active-low reset clears top, size, generation
// and the link valid bits, so all links read as none right after reset.
// ----------------------------------------------------------------------------
module linked_lifo_with_generation_tag (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] node, [39:8] expect_gen, [47:40] expect_size,
  // [79:48] incr_amount, [111:80] new_gen
  input  logic [llg_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [2:0] kind
  input  logic [llg_pkg::KIND_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] done_res, [8:1] node_out, [16:9] count_out, [48:17] gen_out,
  // [49] is_empty, [57:50] size_now, [89:58] gen_now, rest zero
  output logic [llg_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import llg_pkg::*;

  llg_cmd_t cmd;

  llg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  llg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hw/rtl/llg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llg_ctrl
// Sequencer: takes one item, lets its link read register, then commits
// it once the result register is free. Owns the result valid flag.
// ----------------------------------------------------------------------------
module llg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output llg_pkg::llg_cmd_t  cmd
);
  import llg_pkg::*;

  llg_state_t state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       exec_go;

  assign exec_go = (state_r == S_EXEC) && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_EXEC: begin
        cmd.exec = exec_go;
      end
      default: ;
    endcase
  end

  // hold the result until its transfer; a new one can load in the same cycle
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (exec_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;

endmodule

// ===== hw/rtl/llg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llg_dp
// Datapath: item registers, top/size/generation, the link memory with its
// valid bits, the operation logic and the result register.
// ----------------------------------------------------------------------------
module llg_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  llg_pkg::llg_cmd_t                   cmd,
  input  logic [llg_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [llg_pkg::KIND_W-1:0]          in_tuser,
  output logic [llg_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import llg_pkg::*;

  // link memory; an entry never written since reset reads as no link
  logic [NODE_W-1:0]     mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] vld_r;
  logic [NODE_W-1:0]     rd_data_r;
  logic                  rd_vld_r;
  logic [NODE_BITS-1:0]  rd_addr;
  logic [NODE_W-1:0]     link;

  // item registers
  llg_kind_t             kind_r;
  logic [NODE_W-1:0]     node_r;
  logic [GEN_BITS-1:0]   egen_r;
  logic [SIZE_W-1:0]     esize_r;
  logic [GEN_BITS-1:0]   incr_r;
  logic [GEN_BITS-1:0]   ngen_r;

  // stack state
  logic [NODE_W-1:0]     top_r, top_nxt;
  logic [SIZE_W-1:0]     cnt_r, cnt_nxt;
  logic [GEN_BITS-1:0]   gen_r, gen_nxt;

  // operation results
  logic                  done;
  logic [NODE_W-1:0]     nout;
  logic [SIZE_W-1:0]     cnt_seen;
  logic                  wr_en;
  logic [NODE_BITS-1:0]  wr_addr;
  logic [NODE_W-1:0]     wr_data;
  logic                  node_ok;
  logic                  push_ok;
  logic                  gen_match;
  llg_kind_t             kind_in;

  logic [OUT_TDATA_W-1:0] out_r;

  function automatic logic [NODE_BITS-1:0] to_addr(input logic [NODE_W-1:0] n);
    return NODE_BITS'(n);
  endfunction

  assign kind_in = llg_kind_t'(in_tuser);
  // pops read the top's link, everything else the named node's link
  assign rd_addr = (kind_in == K_POP || kind_in == K_POP_IF_GEN_SIZE) ?
                   to_addr(top_r) : to_addr(in_tdata[IN_NODE_LO +: NODE_W]);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data_r <= mem[rd_addr];
      kind_r    <= kind_in;
      node_r    <= in_tdata[IN_NODE_LO +: NODE_W];
      egen_r    <= GEN_BITS'(in_tdata[IN_EGEN_LO +: GFLD_W]);
      esize_r   <= in_tdata[IN_ESIZE_LO +: SIZE_W];
      incr_r    <= GEN_BITS'(in_tdata[IN_INCR_LO +: GFLD_W]);
      ngen_r    <= GEN_BITS'(in_tdata[IN_NGEN_LO +: GFLD_W]);
    end
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (cmd.exec && wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign link      = rd_vld_r ? rd_data_r : '0;
  assign node_ok   = (node_r != '0) && (32'(node_r) < 32'(NODE_COUNT));
  assign push_ok   = node_ok && (link == '0) && (node_r != top_r) && (cnt_r != SIZE_MAX);
  assign gen_match = (gen_r == egen_r);

  always_comb begin
    top_nxt  = top_r;
    cnt_nxt  = cnt_r;
    gen_nxt  = gen_r;
    done     = 1'b0;
    nout     = '0;
    cnt_seen = cnt_r;
    wr_en    = 1'b0;
    wr_addr  = to_addr(node_r);
    wr_data  = top_r;
    unique case (kind_r)
      K_PUSH, K_PUSH_IF_GEN: begin
        if (kind_r == K_PUSH || gen_match) begin
          nout = top_r;
          if (push_ok) begin
            done    = 1'b1;
            wr_en   = 1'b1;
            top_nxt = node_r;
            cnt_nxt = cnt_r + SIZE_W'(1);
          end
        end
      end
      K_POP, K_POP_IF_GEN_SIZE: begin
        if (top_r != '0 &&
            (kind_r == K_POP || (gen_match && cnt_r == esize_r))) begin
          // unlink the old top and retire it
          done    = 1'b1;
          nout    = top_r;
          top_nxt = link;
          wr_en   = 1'b1;
          wr_addr = to_addr(top_r);
          wr_data = '0;
          gen_nxt = gen_r + GEN_BITS'(1);
          cnt_nxt = (cnt_r != '0) ? cnt_r - SIZE_W'(1) : '0;
        end
      end
      K_DETACH_ALL: begin
        if (top_r != '0 || incr_r != '0) begin
          done    = 1'b1;
          nout    = top_r;
          top_nxt = '0;
          cnt_nxt = '0;
          gen_nxt = gen_r + incr_r;
        end
      end
      K_DETACH_OR_ADD: begin
        if (top_r == '0) begin
          gen_nxt  = gen_r + incr_r;
          done     = (incr_r != '0);
          cnt_seen = '0;
        end else begin
          done    = 1'b1;
          nout    = top_r;
          top_nxt = '0;
          cnt_nxt = '0;
        end
      end
      K_DETACH_IF_GEN: begin
        if (gen_match) begin
          done    = 1'b1;
          nout    = top_r;
          top_nxt = '0;
          cnt_nxt = '0;
          gen_nxt = ngen_r;
        end
      end
      K_READ_LINK: begin
        if (node_ok) begin
          nout = link;
        end
        done = (nout != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      cnt_r <= '0;
      gen_r <= '0;
    end else if (cmd.exec) begin
      top_r <= top_nxt;
      cnt_r <= cnt_nxt;
      gen_r <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= OUT_TDATA_W'({
        gen_nxt[GFLD_W-1:0] & GFLD_W'(gen_nxt),
        cnt_nxt,
        (top_nxt == '0),
        GFLD_W'(gen_r),
        cnt_seen,
        nout,
        done
      });
    end
  end

  assign out_tdata = out_r;

endmodule

// ===== hw/rtl/llg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llg_checker
// Port-level checks for the linked LIFO, bound to the top level.
// ----------------------------------------------------------------------------
module llg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [llg_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import llg_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: no transfer on the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  // with the result register free, the result follows the capture and commit steps without a stall
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |-> ##2 out_tvalid)
    else $error("result late");

endmodule

bind linked_lifo_with_generation_tag llg_checker u_llg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
